// File: rtl/gimbal_to_chassis_velocity_rotation_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the gimbal-to-chassis velocity rotation core
// Implication checks clocked by clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GIMBAL_TO_CHASSIS_VELOCITY_ROTATION_CORE_ASSERT_SVH
`define GIMBAL_TO_CHASSIS_VELOCITY_ROTATION_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCVR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GCVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gcvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvr_pkg
// Shared types, constants and the CORDIC arc table of the rotation core.
// ----------------------------------------------------------------------------
package gcvr_pkg;

  // Angles in 1/256 degree.
  localparam logic signed [18:0] FULL_TURN_W  = 19'sd92160;
  localparam logic signed [18:0] HALF_TURN_W  = 19'sd46080;
  localparam logic signed [16:0] HALF_TURN    = 17'sd46080;
  localparam logic signed [16:0] QUARTER_TURN = 17'sd23040;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  // Configuration register indexes.
  localparam logic [1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [1:0] REG_DIRECTION   = 2'd1;

  typedef struct packed {
    logic                start;
    logic signed [16:0]  angle;
  } cordic_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic signed [31:0]  cos_v;
    logic signed [31:0]  sin_v;
  } cordic_rsp_t;

  typedef struct packed {
    logic                start;
    logic signed [15:0]  vx;
    logic signed [15:0]  vy;
    logic signed [31:0]  cos_v;
    logic signed [31:0]  sin_v;
  } mac_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic signed [15:0]  x;
    logic signed [15:0]  y;
  } mac_rsp_t;

  // Arc tangent of 2^-i in 2^-24 degree.
  function automatic logic signed [33:0] arc_at(input logic [3:0] idx);
    logic signed [33:0] a;
    case (idx)
      4'd0:    a = 34'sd754974720;
      4'd1:    a = 34'sd445687602;
      4'd2:    a = 34'sd235489089;
      4'd3:    a = 34'sd119537938;
      4'd4:    a = 34'sd60000934;
      4'd5:    a = 34'sd30029717;
      4'd6:    a = 34'sd15018523;
      4'd7:    a = 34'sd7509720;
      4'd8:    a = 34'sd3754917;
      4'd9:    a = 34'sd1877466;
      4'd10:   a = 34'sd938734;
      4'd11:   a = 34'sd469367;
      4'd12:   a = 34'sd234683;
      4'd13:   a = 34'sd117342;
      4'd14:   a = 34'sd58671;
      4'd15:   a = 34'sd29336;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage

// File: rtl/gcvr_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvr channel interfaces
// Valid/ready channels for input items, results and configuration writes.
// ----------------------------------------------------------------------------
interface gcvr_in_if;
  logic               valid;
  logic               ready;
  logic [16:0]        motor_angle;
  logic               motor_online;
  logic               imu_ready;
  logic signed [31:0] chassis_yaw;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;

  modport source (output valid, motor_angle, motor_online, imu_ready, chassis_yaw,
                  vel_x, vel_y, input ready);
  modport sink (input valid, motor_angle, motor_online, imu_ready, chassis_yaw,
                vel_x, vel_y, output ready);
endinterface

interface gcvr_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rot_vel_x;
  logic signed [15:0] rot_vel_y;
  logic signed [16:0] relative_yaw;
  logic signed [31:0] world_yaw;
  logic               status;

  modport source (output valid, rot_vel_x, rot_vel_y, relative_yaw,
                  world_yaw, status, input ready);
  modport sink (input valid, rot_vel_x, rot_vel_y, relative_yaw,
                world_yaw, status, output ready);
endinterface

interface gcvr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/gcvr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvr_cordic
// Iterative rotation-mode CORDIC: one add/shift step per cycle, 16 steps.
// ----------------------------------------------------------------------------
module gcvr_cordic (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gcvr_pkg::cordic_req_t req,
  output gcvr_pkg::cordic_rsp_t rsp
);

  logic signed [33:0] x_r, y_r, z_r;
  logic [3:0]         step_r;
  logic               busy_r;
  logic               done_r;
  logic               flip_r;

  logic signed [16:0] ang_f;
  logic               flip_nxt;
  logic signed [33:0] x_sh, y_sh, arc, neg_x, neg_y;
  logic               pos;

  // Fold the angle into [-90, 90] degrees; the half turn negates both outputs.
  always_comb begin
    ang_f    = req.angle;
    flip_nxt = 1'b0;
    if (req.angle > gcvr_pkg::QUARTER_TURN) begin
      ang_f    = req.angle - gcvr_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end else if (req.angle < -gcvr_pkg::QUARTER_TURN) begin
      ang_f    = req.angle + gcvr_pkg::HALF_TURN;
      flip_nxt = 1'b1;
    end
  end

  assign x_sh = x_r >>> step_r;
  assign y_sh = y_r >>> step_r;
  assign arc  = gcvr_pkg::arc_at(step_r);
  assign pos  = ~z_r[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 4'd1;
        if (step_r == 4'(gcvr_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r    <= gcvr_pkg::CORDIC_GAIN_Q30;
      y_r    <= '0;
      z_r    <= {{1{ang_f[16]}}, ang_f, 16'b0};
      flip_r <= flip_nxt;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - y_sh;
        y_r <= y_r + x_sh;
        z_r <= z_r - arc;
      end else begin
        x_r <= x_r + y_sh;
        y_r <= y_r - x_sh;
        z_r <= z_r + arc;
      end
    end
  end

  assign neg_x = -x_r;
  assign neg_y = -y_r;

  assign rsp.busy  = busy_r;
  assign rsp.done  = done_r;
  assign rsp.cos_v = flip_r ? neg_x[31:0] : x_r[31:0];
  assign rsp.sin_v = flip_r ? neg_y[31:0] : y_r[31:0];

endmodule

// File: rtl/gcvr_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcvr_mac
// Shared 16x32 multiplier with two accumulators for the rotated speeds.
// ----------------------------------------------------------------------------
module gcvr_mac (
  input  logic              clk,
  input  logic              rst_n,
  input  gcvr_pkg::mac_req_t req,
  output gcvr_pkg::mac_rsp_t rsp
);

  localparam logic signed [49:0] ROUND_HALF = 50'sd536870912;

  logic               busy_r;
  logic               done_r;
  logic [2:0]         issue_r;
  logic               pend_r;
  logic [1:0]         acc_id_r;
  logic signed [47:0] prod_r;
  logic signed [49:0] accx_r, accy_r;

  logic signed [15:0] op_a;
  logic signed [31:0] op_b;
  logic signed [47:0] prod;
  logic signed [49:0] prod_ext;

  function automatic logic signed [15:0] sat16(input logic signed [49:0] acc);
    logic signed [19:0] q;
    logic signed [15:0] r;
    q = acc[49:30];
    if (q > 20'sd32767) r = 16'sh7FFF;
    else if (q < -20'sd32768) r = 16'sh8000;
    else r = q[15:0];
    return r;
  endfunction

  // Product order: vx*cos, vy*sin, vx*sin, vy*cos.
  always_comb begin
    case (issue_r[1:0])
      2'd0:    begin op_a = req.vx; op_b = req.cos_v; end
      2'd1:    begin op_a = req.vy; op_b = req.sin_v; end
      2'd2:    begin op_a = req.vx; op_b = req.sin_v; end
      default: begin op_a = req.vy; op_b = req.cos_v; end
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = {{2{prod_r[47]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      pend_r  <= 1'b0;
      issue_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        issue_r <= '0;
        pend_r  <= 1'b0;
      end else if (busy_r) begin
        if (issue_r != 3'd4) begin
          issue_r <= issue_r + 3'd1;
          pend_r  <= 1'b1;
        end else begin
          pend_r <= 1'b0;
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      accx_r <= ROUND_HALF;
      accy_r <= ROUND_HALF;
    end else if (busy_r) begin
      prod_r   <= prod;
      acc_id_r <= issue_r[1:0];
      if (pend_r) begin
        case (acc_id_r)
          2'd0:    accx_r <= accx_r + prod_ext;
          2'd1:    accx_r <= accx_r - prod_ext;
          default: accy_r <= accy_r + prod_ext;
        endcase
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.x    = sat16(accx_r);
  assign rsp.y    = sat16(accy_r);

endmodule

// File: rtl/gimbal_to_chassis_velocity_rotation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gimbal_to_chassis_velocity_rotation_core
// Rotates a gimbal-frame velocity into the chassis frame by the gimbal yaw.
// ----------------------------------------------------------------------------
// The core takes one request at a time and returns one result per request:
// the PREP state wraps the relative yaw, the WORLD state forms the world
// yaw and starts the CORDIC (16 add/shift iterations of one shared unit),
// then the single shared 16x32 multiply-accumulate forms four products, and
// the result is loaded into the output register. The input stays not ready
// until the result has been loaded into the output register, so a new
// request is not taken before the last one is finished; a finished result
// waits in the output register until it is taken.
// Configuration writes are always taken and should only be issued while the
// core is idle.
`include "gimbal_to_chassis_velocity_rotation_core_assert.svh"

module gimbal_to_chassis_velocity_rotation_core (
  input  logic              clk,
  input  logic              rst_n,
  gcvr_in_if.sink           in_ch,
  gcvr_out_if.source        out_ch,
  gcvr_cfg_if.sink          cfg_ch
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_WORLD = 6'b000100,
    S_ROT   = 6'b001000,
    S_MIX   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [16:0]        zero_offset_r;
  logic               dir_neg_r;

  logic [16:0]        angle_r;
  logic               online_r;
  logic               imu_r;
  logic signed [31:0] cyaw_r;
  logic signed [15:0] vx_r, vy_r;

  logic signed [16:0] rel_yaw_r;
  logic signed [31:0] world_yaw_r;
  logic               status_r;

  logic               out_valid_r;
  logic signed [15:0] out_x_r, out_y_r;
  logic signed [16:0] out_rel_r;
  logic signed [31:0] out_world_r;
  logic               out_status_r;

  logic               in_fire;
  logic               out_load;

  logic signed [18:0] d0, d1, d2;
  logic signed [32:0] wsum;
  logic signed [31:0] wsat;

  gcvr_pkg::cordic_req_t creq;
  gcvr_pkg::cordic_rsp_t crsp;
  gcvr_pkg::mac_req_t    mreq;
  gcvr_pkg::mac_rsp_t    mrsp;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_load     = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  // Encoder difference, sign and wrap into (-180, 180] degrees. The raw
  // difference stays within one and a half turns, so one correction is enough.
  always_comb begin
    d0 = $signed({2'b00, angle_r}) - $signed({2'b00, zero_offset_r});
    d1 = dir_neg_r ? -d0 : d0;
    if (d1 > gcvr_pkg::HALF_TURN_W) d2 = d1 - gcvr_pkg::FULL_TURN_W;
    else if (d1 <= -gcvr_pkg::HALF_TURN_W) d2 = d1 + gcvr_pkg::FULL_TURN_W;
    else d2 = d1;
  end

  always_comb begin
    wsum = {cyaw_r[31], cyaw_r} + {{16{rel_yaw_r[16]}}, rel_yaw_r};
    if (wsum[32] != wsum[31]) wsat = wsum[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else wsat = wsum[31:0];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_PREP;
      S_PREP:  state_nxt = S_WORLD;
      S_WORLD: state_nxt = S_ROT;
      S_ROT:   if (crsp.done) state_nxt = S_MIX;
      S_MIX:   if (mrsp.done) state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      zero_offset_r <= '0;
      dir_neg_r     <= 1'b0;
      rel_yaw_r     <= '0;
      world_yaw_r   <= '0;
      status_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          gcvr_pkg::REG_ZERO_OFFSET: zero_offset_r <= cfg_ch.data;
          gcvr_pkg::REG_DIRECTION:   dir_neg_r     <= cfg_ch.data[0];
          default: ;
        endcase
      end
      if (state_r == S_PREP && online_r) rel_yaw_r <= d2[16:0];
      if (state_r == S_WORLD) begin
        if (online_r && imu_r) begin
          world_yaw_r <= wsat;
          status_r    <= 1'b1;
        end else begin
          status_r <= 1'b0;
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      angle_r  <= in_ch.motor_angle;
      online_r <= in_ch.motor_online;
      imu_r    <= in_ch.imu_ready;
      cyaw_r   <= in_ch.chassis_yaw;
      vx_r     <= in_ch.vel_x;
      vy_r     <= in_ch.vel_y;
    end
    if (out_load) begin
      out_x_r      <= mrsp.x;
      out_y_r      <= mrsp.y;
      out_rel_r    <= rel_yaw_r;
      out_world_r  <= world_yaw_r;
      out_status_r <= status_r;
    end
  end

  assign creq.start = (state_r == S_WORLD);
  assign creq.angle = rel_yaw_r;

  gcvr_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (creq),
    .rsp   (crsp)
  );

  assign mreq.start = (state_r == S_ROT) && crsp.done;
  assign mreq.vx    = vx_r;
  assign mreq.vy    = vy_r;
  assign mreq.cos_v = crsp.cos_v;
  assign mreq.sin_v = crsp.sin_v;

  gcvr_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.rot_vel_x    = out_x_r;
  assign out_ch.rot_vel_y    = out_y_r;
  assign out_ch.relative_yaw = out_rel_r;
  assign out_ch.world_yaw    = out_world_r;
  assign out_ch.status       = out_status_r;

  `GCVR_ASSERT_NEXT(a_accept_starts_prep, in_fire, state_r == S_PREP, "request did not start work")
  `GCVR_ASSERT_SAME(a_idle_units_quiet, state_r == S_IDLE, !crsp.busy && !mrsp.busy, "unit busy while idle")
  `GCVR_ASSERT_SAME(a_rel_yaw_range, 1'b1, rel_yaw_r > -gcvr_pkg::HALF_TURN && rel_yaw_r <= gcvr_pkg::HALF_TURN, "relative yaw out of range")
  `GCVR_ASSERT_SAME(a_valid_from_out, $rose(out_valid_r), $past(state_r == S_OUT), "result shown without finishing")

endmodule
